[rtl/fnpll_pkg.sv]
// Shared types, constants and word-building functions of the fractional-N
// register word generator; depends on nothing; used by all but fnpll_div.
package fnpll_pkg;

  // Field and datapath widths
  localparam int FreqW  = 23;  // requested frequency in kHz
  localparam int DivW   = 3;   // output divider exponent
  localparam int RefW   = 8;   // reference clock in MHz
  localparam int ModW   = 12;  // fractional modulus
  localparam int NumW   = 23;  // N = freq << div always fits 23 bits
  localparam int DenW   = 18;  // D = ref * 1000
  localparam int IntW   = 14;  // INT = N / D stays below 8389
  localparam int FracW  = 12;  // FRAC never exceeds the modulus
  localparam int ProdW  = DenW + ModW;   // remainder times modulus
  localparam int XNumW  = 32;            // 2 * rem * mod + D
  localparam int XDenW  = DenW + 1;      // 2 * D
  localparam int WordW  = 32;
  localparam int IdxW   = 3;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam int KhzPerMhz  = 1000;
  localparam int ItemCycles = 6;   // words per item on the result channel
  localparam logic [2:0] HoldCycles = 3'(ItemCycles - 1);

  // Divider thresholds in kHz
  localparam logic [FreqW-1:0] Thr6 = 23'd68750;
  localparam logic [FreqW-1:0] Thr5 = 23'd137500;
  localparam logic [FreqW-1:0] Thr4 = 23'd275000;
  localparam logic [FreqW-1:0] Thr3 = 23'd550000;
  localparam logic [FreqW-1:0] Thr2 = 23'd1100000;
  localparam logic [FreqW-1:0] Thr1 = 23'd2200000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegRefClk   = 3'd0,
    RegModulus  = 3'd1,
    RegFbSel    = 3'd2,
    RegPwrDown  = 3'd3,
    RegRfEn     = 3'd4,
    RegRfPwr    = 3'd5,
    RegAuxEn    = 3'd6,
    RegAuxPwr   = 3'd7
  } fnpll_reg_e;

  // Synthesizer word indexes
  localparam logic [IdxW-1:0] WordR0 = 3'd0;
  localparam logic [IdxW-1:0] WordR1 = 3'd1;
  localparam logic [IdxW-1:0] WordR2 = 3'd2;
  localparam logic [IdxW-1:0] WordR3 = 3'd3;
  localparam logic [IdxW-1:0] WordR4 = 3'd4;
  localparam logic [IdxW-1:0] WordR5 = 3'd5;

  typedef struct packed {
    logic [RefW-1:0] ref_clock_mhz;
    logic [ModW-1:0] modulus;
    logic            feedback_select;
    logic            power_down;
    logic            rf_enable;
    logic [1:0]      rf_power;
    logic            aux_enable;
    logic [1:0]      aux_power;
  } fnpll_cfg_t;

  localparam fnpll_cfg_t CfgReset = '{
    ref_clock_mhz:   8'd10,
    modulus:         12'd1000,
    feedback_select: 1'b1,
    power_down:      1'b0,
    rf_enable:       1'b1,
    rf_power:        2'd0,
    aux_enable:      1'b0,
    aux_power:       2'd0
  };

  // Fixed parts of the register words
  localparam logic [WordW-1:0] R1Fixed = (32'd1 << 27) | (32'd1 << 15) | 32'd1;
  localparam logic [WordW-1:0] R2Fixed = (32'd3 << 29) | (32'd6 << 26) | (32'd1 << 14)
                                       | (32'd14 << 9) | (32'd1 << 6) | 32'd2;
  localparam logic [WordW-1:0] R3Fixed = (32'd150 << 3) | 32'd3;
  localparam logic [WordW-1:0] R4Fixed = (32'd200 << 12) | 32'd4;
  localparam logic [WordW-1:0] R5Fixed = (32'd1 << 22) | (32'd3 << 19) | 32'd5;

  // Pick the output divider exponent from the frequency thresholds
  function automatic logic [DivW-1:0] fnpll_pick_div(input logic [FreqW-1:0] khz);
    logic [DivW-1:0] div;
    div = 3'd0;
    if (khz < Thr1) div = 3'd1;
    if (khz < Thr2) div = 3'd2;
    if (khz < Thr3) div = 3'd3;
    if (khz < Thr4) div = 3'd4;
    if (khz < Thr5) div = 3'd5;
    if (khz < Thr6) div = 3'd6;
    return div;
  endfunction

  // Build one synthesizer word from the item results and the configuration
  function automatic logic [WordW-1:0] fnpll_word(input logic [IdxW-1:0]  idx,
                                                  input logic [IntW-1:0]  int_v,
                                                  input logic [FracW-1:0] frac,
                                                  input logic [DivW-1:0]  div,
                                                  input fnpll_cfg_t       cfg);
    logic [WordW-1:0] word;
    unique case (idx)
      WordR0: word = (WordW'(int_v) << 15) | (WordW'(frac) << 3);
      WordR1: word = R1Fixed | (WordW'(cfg.modulus) << 3);
      WordR2: word = R2Fixed | (WordW'(cfg.power_down) << 5);
      WordR3: word = R3Fixed;
      WordR4: word = R4Fixed | (WordW'(cfg.feedback_select) << 23) | (WordW'(div) << 20)
                   | (WordW'(cfg.aux_enable) << 8) | (WordW'(cfg.aux_power) << 6)
                   | (WordW'(cfg.rf_enable) << 5) | (WordW'(cfg.rf_power) << 3);
      WordR5: word = R5Fixed;
      default: word = '0;
    endcase
    return word;
  endfunction

endpackage

[rtl/fnpll_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, with a
// side tag that travels along. Depends on nothing outside this file.
module fnpll_div #(
  parameter int NumW = 23,
  parameter int DenW = 18,
  parameter int QuoW = 14,
  parameter int TagW = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [QuoW-1:0] quo_o,
  output logic [NumW-1:0] rem_o,
  output logic [TagW-1:0] tag_o
);

  // Compare width covers both the partial remainder and the shifted divisor
  localparam int CmpW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  // Stage g is the register after bit step g
  logic            vld_q [QuoW];
  logic [NumW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [TagW-1:0] tag_q [QuoW];

  for (genvar g = 0; g < QuoW; g++) begin : g_step
    localparam int Bit = QuoW - 1 - g;
    logic            vld_in;
    logic [NumW-1:0] rem_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW-1:0] den_in;
    logic [TagW-1:0] tag_in;
    logic [CmpW-1:0] rem_ext;
    logic [CmpW-1:0] sub_ext;
    logic            fits;

    // Take the item from the ports on the first step, else from the step before
    if (g == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_link
      assign vld_in = vld_q[g-1];
      assign rem_in = rem_q[g-1];
      assign quo_in = quo_q[g-1];
      assign den_in = den_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    // Try to subtract the divisor aligned to this quotient bit
    assign rem_ext = CmpW'(rem_in);
    assign sub_ext = CmpW'(den_in) << Bit;
    assign fits    = rem_ext >= sub_ext;

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    // Advance the payload
    always_ff @(posedge clk_i) begin
      rem_q[g] <= fits ? NumW'(rem_ext - sub_ext) : rem_in;
      quo_q[g] <= (quo_in << 1) | QuoW'(fits);
      den_q[g] <= den_in;
      tag_q[g] <= tag_in;
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign rem_o   = rem_q[QuoW-1];
  assign tag_o   = tag_q[QuoW-1];

endmodule

[rtl/fnpll_ser.sv]
// Output serializer: turns one finished item into six register words, R5
// down to R0, on consecutive cycles. Depends on fnpll_pkg.
module fnpll_ser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [fnpll_pkg::IntW-1:0]  int_i,
  input  logic [fnpll_pkg::FracW-1:0] frac_i,
  input  logic [fnpll_pkg::DivW-1:0]  div_i,
  input  fnpll_pkg::fnpll_cfg_t     cfg_i,
  output logic                      strobe_o,
  output logic [fnpll_pkg::WordW-1:0] word_o,
  output logic [fnpll_pkg::IdxW-1:0]  index_o,
  output logic                      last_o
);
  import fnpll_pkg::*;

  logic            run_q, run_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IntW-1:0] int_q;
  logic [FracW-1:0] frac_q;
  logic [DivW-1:0] div_q;
  logic            strobe_q;
  logic [WordW-1:0] word_q;
  logic [IdxW-1:0] index_q;
  logic            last_q;

  // Load a new item or step down through the word indexes
  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (valid_i) begin
      run_d = 1'b1;
      cnt_d = WordR5;
    end else if (run_q) begin
      run_d = (cnt_q != WordR0);
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      cnt_q    <= WordR0;
      strobe_q <= 1'b0;
    end else begin
      run_q    <= run_d;
      cnt_q    <= cnt_d;
      strobe_q <= run_q;
    end
  end

  // Hold the item results; register the outgoing word
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      int_q  <= int_i;
      frac_q <= frac_i;
      div_q  <= div_i;
    end
    word_q  <= fnpll_word(cnt_q, int_q, frac_q, div_q, cfg_i);
    index_q <= cnt_q;
    last_q  <= (cnt_q == WordR0);
  end

  assign strobe_o = strobe_q;
  assign word_o   = word_q;
  assign index_o  = index_q;
  assign last_o   = last_q;

  // A new item only arrives once the previous run is on its last word
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (!run_q || cnt_q == WordR0))
    else $error("item arrived while a word run was still in progress");

  // Every running cycle produces a strobe in the cycle after it
  a_run_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |=> strobe_o)
    else $error("running serializer dropped a word");

  // The final step of a run emits the last word
  a_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && cnt_q == WordR0) |=> (strobe_o && last_o))
    else $error("run ended without the last word");

endmodule

[rtl/frac_n_pll_register_words.sv]
// Top level of the fractional-N register word generator: configuration
// registers, entry stage, two pipelined dividers and the word serializer.
// Depends on fnpll_pkg, fnpll_div and fnpll_ser.
//
// Usage:
//   Configuration goes through the APB-style port (registers at 4*i); write
//   it only while no item is in flight. pready is always high.
//   An item (freq_khz_i) is taken at a rising edge with start high and busy
//   low. Each item yields six words, R5 first down to R0, on consecutive
//   cycles, each marked by word_strobe_o for one cycle; last_word_o flags
//   R0.
//   The single result channel carries six words per item, so after an
//   accept busy stays high long enough that the word runs of successive
//   items do not overlap. Up to five items are in the divider pipeline
//   at once.
//   The pipeline is one entry stage, a 14-stage INT divider (one quotient
//   bit per stage), a multiply stage, a numerator stage, a 12-stage FRAC
//   divider and the serializer.
//   Reset clears the pipeline and returns the registers to their defaults.
//   The receiver cannot stall; words are dropped if not taken.
module frac_n_pll_register_words (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic [fnpll_pkg::FreqW-1:0]   freq_khz_i,
  // result channel
  output logic                          word_strobe_o,
  output logic [fnpll_pkg::WordW-1:0]   reg_word_o,
  output logic [fnpll_pkg::IdxW-1:0]    reg_index_o,
  output logic                          last_word_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fnpll_pkg::AddrW-1:0]   paddr,
  input  logic [fnpll_pkg::DataW-1:0]   pwdata,
  output logic [fnpll_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import fnpll_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  fnpll_cfg_t cfg_q, cfg_d;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  // Apply a register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        RegRefClk:  cfg_d.ref_clock_mhz   = pwdata[RefW-1:0];
        RegModulus: cfg_d.modulus         = pwdata[ModW-1:0];
        RegFbSel:   cfg_d.feedback_select = pwdata[0];
        RegPwrDown: cfg_d.power_down      = pwdata[0];
        RegRfEn:    cfg_d.rf_enable       = pwdata[0];
        RegRfPwr:   cfg_d.rf_power        = pwdata[1:0];
        RegAuxEn:   cfg_d.aux_enable      = pwdata[0];
        RegAuxPwr:  cfg_d.aux_power       = pwdata[1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      RegRefClk:  prdata = DataW'(cfg_q.ref_clock_mhz);
      RegModulus: prdata = DataW'(cfg_q.modulus);
      RegFbSel:   prdata = DataW'(cfg_q.feedback_select);
      RegPwrDown: prdata = DataW'(cfg_q.power_down);
      RegRfEn:    prdata = DataW'(cfg_q.rf_enable);
      RegRfPwr:   prdata = DataW'(cfg_q.rf_power);
      RegAuxEn:   prdata = DataW'(cfg_q.aux_enable);
      RegAuxPwr:  prdata = DataW'(cfg_q.aux_power);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Item intake: hold off for the serializer's six-word run
  // ---------------------------------------------------------------
  logic       accept;
  logic [2:0] hold_q, hold_d;

  assign accept = start && !busy;
  assign busy   = (hold_q != 3'd0);

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = HoldCycles;
    end else if (hold_q != 3'd0) begin
      hold_d = hold_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 3'd0;
    end else begin
      hold_q <= hold_d;
    end
  end

  // ---------------------------------------------------------------
  // Entry stage: divider exponent, N and D
  // ---------------------------------------------------------------
  logic              a_vld_q;
  logic [NumW-1:0]   a_num_q;
  logic [DenW-1:0]   a_den_q;
  logic [DivW-1:0]   a_div_q;
  logic [DivW-1:0]   in_div;
  logic [FreqW+5:0]  in_shift;
  logic [RefW-1:0]   ref_eff;

  assign in_div   = fnpll_pick_div(freq_khz_i);
  assign in_shift = (FreqW+6)'(freq_khz_i) << in_div;
  // A zero reference counts as 1 MHz
  assign ref_eff  = (cfg_q.ref_clock_mhz == '0) ? RefW'(1) : cfg_q.ref_clock_mhz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_num_q <= in_shift[NumW-1:0];
    a_den_q <= DenW'(ref_eff) * DenW'(KhzPerMhz);
    a_div_q <= in_div;
  end

  // ---------------------------------------------------------------
  // INT = N / D, remainder kept for the fraction
  // ---------------------------------------------------------------
  localparam int ITagW = DenW + DivW;

  logic              i_vld;
  logic [IntW-1:0]   i_quo;
  logic [NumW-1:0]   i_rem;
  logic [ITagW-1:0]  i_tag;

  fnpll_div #(
    .NumW (NumW),
    .DenW (DenW),
    .QuoW (IntW),
    .TagW (ITagW)
  ) u_int_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_vld_q),
    .num_i   (a_num_q),
    .den_i   (a_den_q),
    .tag_i   ({a_den_q, a_div_q}),
    .valid_o (i_vld),
    .quo_o   (i_quo),
    .rem_o   (i_rem),
    .tag_o   (i_tag)
  );

  // ---------------------------------------------------------------
  // Multiply stage: remainder times modulus
  // ---------------------------------------------------------------
  logic              m_vld_q;
  logic [ProdW-1:0]  m_prod_q;
  logic [DenW-1:0]   m_den_q;
  logic [IntW-1:0]   m_int_q;
  logic [DivW-1:0]   m_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= i_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m_prod_q <= ProdW'(i_rem[DenW-1:0]) * ProdW'(cfg_q.modulus);
    m_den_q  <= i_tag[ITagW-1:DivW];
    m_div_q  <= i_tag[DivW-1:0];
    m_int_q  <= i_quo;
  end

  // ---------------------------------------------------------------
  // Numerator stage: 2*rem*mod + D over 2*D rounds half up
  // ---------------------------------------------------------------
  localparam int FTagW = IntW + DivW;

  logic              x_vld_q;
  logic [XNumW-1:0]  x_num_q;
  logic [XDenW-1:0]  x_den_q;
  logic [FTagW-1:0]  x_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= 1'b0;
    end else begin
      x_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_num_q <= XNumW'({m_prod_q, 1'b0}) + XNumW'(m_den_q);
    x_den_q <= {m_den_q, 1'b0};
    x_tag_q <= {m_int_q, m_div_q};
  end

  // ---------------------------------------------------------------
  // FRAC divider
  // ---------------------------------------------------------------
  logic              f_vld;
  logic [FracW-1:0]  f_quo;
  logic [FTagW-1:0]  f_tag;

  fnpll_div #(
    .NumW (XNumW),
    .DenW (XDenW),
    .QuoW (FracW),
    .TagW (FTagW)
  ) u_frac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_vld_q),
    .num_i   (x_num_q),
    .den_i   (x_den_q),
    .tag_i   (x_tag_q),
    .valid_o (f_vld),
    .quo_o   (f_quo),
    .rem_o   (),
    .tag_o   (f_tag)
  );

  // ---------------------------------------------------------------
  // Word serializer
  // ---------------------------------------------------------------
  fnpll_ser u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f_vld),
    .int_i    (f_tag[FTagW-1:DivW]),
    .frac_i   (f_quo),
    .div_i    (f_tag[DivW-1:0]),
    .cfg_i    (cfg_q),
    .strobe_o (word_strobe_o),
    .word_o   (reg_word_o),
    .index_o  (reg_index_o),
    .last_o   (last_word_o)
  );

  // An accepted item blocks the next one for the length of a word run
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // Words of a run come out with falling indexes on back-to-back cycles
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_strobe_o && reg_index_o != WordR0) |=>
      (word_strobe_o && reg_index_o == $past(reg_index_o) - 3'd1))
    else $error("word run broken or out of order");

  // Rounded fraction never exceeds the modulus
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld |-> (f_quo <= cfg_q.modulus))
    else $error("fraction above modulus");

endmodule

[tb/tb_frac_n_pll_register_words.sv]
// Testbench for frac_n_pll_register_words: drives frequency items and APB
// setting writes, predicts the six register words per item and checks them.
// Depends on fnpll_pkg and the frac_n_pll_register_words RTL.
`timescale 1ns / 100ps

module tb_frac_n_pll_register_words;
  import fnpll_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;
  localparam int PhaseItems  = 55;
  localparam int Phases      = 6;

  // One expected synthesizer word
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [IdxW-1:0]  idx;
    logic             last;
  } pll_word_t;

  // Shadow copy of the setting registers
  typedef struct {
    logic [7:0]  ref_mhz;
    logic [11:0] modulus;
    logic        fb_sel;
    logic        pwr_down;
    logic        rf_en;
    logic [1:0]  rf_pwr;
    logic        aux_en;
    logic [1:0]  aux_pwr;
  } pll_setup_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [FreqW-1:0]    freq_khz_i;
  logic                word_strobe_o;
  logic [WordW-1:0]    reg_word_o;
  logic [IdxW-1:0]     reg_index_o;
  logic                last_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  pll_word_t  words_due[$];
  pll_setup_t setup;
  int         mismatches = 0;
  int         cycle_count = 0;

  frac_n_pll_register_words dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .freq_khz_i    (freq_khz_i),
    .word_strobe_o (word_strobe_o),
    .reg_word_o    (reg_word_o),
    .reg_index_o   (reg_index_o),
    .last_word_o   (last_word_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 50 MHz clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Work out the six words for one frequency under the current setup
  function automatic void predict_words(input logic [FreqW-1:0] khz);
    logic [2:0]       div;
    logic [63:0]      num, den, int_part, rem, frac;
    logic [WordW-1:0] w [6];
    pll_word_t        item;
    if (khz < Thr6)      div = 3'd6;
    else if (khz < Thr5) div = 3'd5;
    else if (khz < Thr4) div = 3'd4;
    else if (khz < Thr3) div = 3'd3;
    else if (khz < Thr2) div = 3'd2;
    else if (khz < Thr1) div = 3'd1;
    else                 div = 3'd0;
    num = 64'(khz) << div;
    // a zero reference counts as 1 MHz
    den = ((setup.ref_mhz == 8'd0) ? 64'd1 : 64'(setup.ref_mhz)) * 64'd1000;
    int_part = (num / den) & 64'hFFFF;
    rem = num % den;
    // round half up; may land exactly on the modulus
    frac = ((64'd2 * rem * 64'(setup.modulus) + den) / (64'd2 * den)) & 64'hFFF;
    w[WordR0] = 32'(int_part << 15) | 32'(frac << 3);
    w[WordR1] = (32'd1 << 27) | (32'd1 << 15) | (32'(setup.modulus) << 3) | 32'd1;
    w[WordR2] = (32'd3 << 29) | (32'd6 << 26) | (32'd1 << 14) | (32'd14 << 9)
              | (32'd1 << 6) | (32'(setup.pwr_down) << 5) | 32'd2;
    w[WordR3] = (32'd150 << 3) | 32'd3;
    w[WordR4] = (32'(setup.fb_sel) << 23) | (32'(div) << 20) | (32'd200 << 12)
              | (32'(setup.aux_en) << 8) | (32'(setup.aux_pwr) << 6)
              | (32'(setup.rf_en) << 5) | (32'(setup.rf_pwr) << 3) | 32'd4;
    w[WordR5] = (32'd1 << 22) | (32'd3 << 19) | 32'd5;
    for (int i = 5; i >= 0; i--) begin
      item.word = w[i];
      item.idx  = IdxW'(i);
      item.last = (i == 0);
      words_due.push_back(item);
    end
  endfunction

  // Check each word against the oldest one due
  always @(posedge clk_i) begin
    pll_word_t due;
    if (rst_ni && word_strobe_o) begin
      if (words_due.size() == 0) begin
        report_mismatch("word with nothing due", reg_word_o, 32'd0);
      end else begin
        due = words_due.pop_front();
        if (reg_word_o !== due.word)
          report_mismatch("reg_word", reg_word_o, due.word);
        if (reg_index_o !== due.idx)
          report_mismatch("reg_index", 32'(reg_index_o), 32'(due.idx));
        if (last_word_o !== due.last)
          report_mismatch("last_word", 32'(last_word_o), 32'(due.last));
      end
    end
  end

  // Write one setting register over APB, with junk above the field
  task automatic write_setting(input fnpll_reg_e sel, input logic [31:0] value);
    int          width;
    logic [31:0] data;
    case (sel)
      RegRefClk: begin
        setup.ref_mhz = value[7:0];
        width = 8;
      end
      RegModulus: begin
        setup.modulus = value[11:0];
        width = 12;
      end
      RegFbSel: begin
        setup.fb_sel = value[0];
        width = 1;
      end
      RegPwrDown: begin
        setup.pwr_down = value[0];
        width = 1;
      end
      RegRfEn: begin
        setup.rf_en = value[0];
        width = 1;
      end
      RegRfPwr: begin
        setup.rf_pwr = value[1:0];
        width = 2;
      end
      RegAuxEn: begin
        setup.aux_en = value[0];
        width = 1;
      end
      default: begin
        setup.aux_pwr = value[1:0];
        width = 2;
      end
    endcase
    data = ($urandom() << width) | (value & ((32'd1 << width) - 32'd1));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({sel, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] ref_mhz, input logic [11:0] modulus,
                           input logic fb_sel, input logic pwr_down, input logic rf_en,
                           input logic [1:0] rf_pwr, input logic aux_en,
                           input logic [1:0] aux_pwr);
    write_setting(RegRefClk, 32'(ref_mhz));
    write_setting(RegModulus, 32'(modulus));
    write_setting(RegFbSel, 32'(fb_sel));
    write_setting(RegPwrDown, 32'(pwr_down));
    write_setting(RegRfEn, 32'(rf_en));
    write_setting(RegRfPwr, 32'(rf_pwr));
    write_setting(RegAuxEn, 32'(aux_en));
    write_setting(RegAuxPwr, 32'(aux_pwr));
  endtask

  // Hold start until the item is taken, then queue its words
  task automatic send_freq(input logic [FreqW-1:0] khz);
    start      <= 1'b1;
    freq_khz_i <= khz;
    do @(posedge clk_i); while (busy);
    predict_words(khz);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 45);
  endfunction

  // Drop start and wait for every word in flight
  task automatic drain_words();
    start <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FreqW-1:0] random_freq();
    logic [FreqW-1:0] edges [6];
    int pick;
    edges = '{Thr6, Thr5, Thr4, Thr3, Thr2, Thr1};
    pick = $urandom_range(0, 99);
    if (pick < 65) return FreqW'($urandom_range(0, 4400000));
    if (pick < 85) return edges[$urandom_range(0, 5)] + FreqW'($urandom_range(0, 40)) - 23'd20;
    return FreqW'($urandom());
  endfunction

  function automatic logic [7:0] random_ref();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd250;
      3: return 8'd255;
      default: return 8'($urandom_range(1, 250));
    endcase
  endfunction

  function automatic logic [11:0] random_modulus();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd2;
      2: return 12'd4095;
      default: return 12'($urandom_range(2, 4095));
    endcase
  endfunction

  // Divider thresholds and field extremes at the reset setup
  task automatic test_divider_thresholds();
    logic [FreqW-1:0] freqs [16];
    freqs = '{23'd0, 23'd68749, 23'd68750, 23'd137499, 23'd137500, 23'd274999,
              23'd275000, 23'd549999, 23'd550000, 23'd1099999, 23'd1100000,
              23'd2199999, 23'd2200000, 23'd4400000, 23'h7FFFFF,
              23'd2209999};  // last one rounds FRAC up to the modulus
    foreach (freqs[i]) begin
      send_freq(freqs[i]);
      pause_sender(i % 3);
    end
    drain_words();
  endtask

  // Zero reference, zero modulus and the register extremes
  task automatic test_setting_extremes();
    write_all(8'd0, 12'd0, 1'b0, 1'b1, 1'b0, 2'd3, 1'b1, 2'd3);
    send_freq(23'd1);
    send_freq(23'd68749);
    send_freq(23'h7FFFFF);
    drain_words();
    write_all(8'd255, 12'd4095, 1'b1, 1'b0, 1'b1, 2'd0, 1'b0, 2'd0);
    send_freq(23'd4400000);
    send_freq(23'd137499);
    send_freq(23'd2199999);
    drain_words();
    write_all(8'd250, 12'd2, 1'b0, 1'b1, 1'b1, 2'd2, 1'b1, 2'd1);
    send_freq(23'd249999);
    send_freq(23'd3000000);
    drain_words();
  endtask

  // Random frequencies under a fresh random setup per phase
  task automatic test_random_items();
    for (int phase = 0; phase < Phases; phase++) begin
      write_all(random_ref(), random_modulus(), 1'($urandom()), 1'($urandom()),
                1'($urandom()), 2'($urandom()), 1'($urandom()), 2'($urandom()));
      for (int n = 0; n < PhaseItems; n++) begin
        send_freq(random_freq());
        // keep the first phase back to back
        if (phase != 0) pause_sender(gap_cycles());
      end
      drain_words();
    end
  endtask

  initial begin
    setup = '{ref_mhz: 8'd10, modulus: 12'd1000, fb_sel: 1'b1, pwr_down: 1'b0,
              rf_en: 1'b1, rf_pwr: 2'd0, aux_en: 1'b0, aux_pwr: 2'd0};
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    freq_khz_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_divider_thresholds();
    test_setting_extremes();
    test_random_items();

    drain_words();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[frac_n_pll_register_words.f]
rtl/fnpll_pkg.sv
rtl/fnpll_div.sv
rtl/fnpll_ser.sv
rtl/frac_n_pll_register_words.sv
tb/tb_frac_n_pll_register_words.sv
